FILE: hw/rtl/hdl_integer_literal_parser_macros.svh
// Assertion macros for the integer literal parser.
// Included by the top level; no other dependencies.
`ifndef HDL_INTEGER_LITERAL_PARSER_MACROS_SVH
`define HDL_INTEGER_LITERAL_PARSER_MACROS_SVH

// same-cycle implication
`define ILP_CHECK(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ilp check failed");

// next-cycle implication
`define ILP_CHECK_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ilp next-cycle check failed");

`endif

FILE: hw/rtl/ilp_pkg.sv
// Shared types and constants for the integer literal parser.
// No dependencies.
package ilp_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [4:0] NOT_HEX   = 5'd16;
  localparam logic [4:0] RADIX_DEC = 5'd10;
  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;
  localparam logic [6:0] SCALE_MAX = 7'd64;

  typedef enum logic [2:0] {
    PH_HEAD,
    PH_BASED,
    PH_CLOSED,
    PH_EXP_START,
    PH_EXP_DIGITS
  } phase_t;

  typedef enum logic [2:0] {
    CL_UNDER,
    CL_HASH,
    CL_EXP,
    CL_PLUS,
    CL_OTHER
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [4:0] digit;
    logic       last;
  } word_t;

  typedef struct packed {
    logic              full;
    logic              nonempty;
    logic [QCNT_W-1:0] level;
  } q_status_t;

  typedef enum logic {
    BS_RUN,
    BS_SCALE
  } bstate_t;

endpackage

FILE: hw/rtl/ilp_front.sv
// Front end: classifies each incoming character into a queue word.
// Depends on ilp_pkg.
module ilp_front import ilp_pkg::*; (
  input  logic [7:0] character,
  input  logic       last,
  output word_t      word
);

  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] d;
    d = NOT_HEX;
    if (c inside {[8'h30:8'h39]}) d = 5'(c - 8'h30);
    else if (c inside {[8'h61:8'h66]}) d = 5'(c - 8'h57);
    else if (c inside {[8'h41:8'h46]}) d = 5'(c - 8'h37);
    return d;
  endfunction

  always_comb begin
    word.digit = hex_of(character);
    word.last  = last;
    case (character)
      CH_UNDER:     word.cls = CL_UNDER;
      CH_HASH:      word.cls = CL_HASH;
      CH_LE, CH_UE: word.cls = CL_EXP;
      CH_PLUS:      word.cls = CL_PLUS;
      default:      word.cls = CL_OTHER;
    endcase
  end

endmodule

FILE: hw/rtl/ilp_queue.sv
// Short word queue between the front end and the back end.
// Depends on ilp_pkg.
module ilp_queue import ilp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  word_t     wr_word,
  input  logic      pop,
  output word_t     rd_word,
  output q_status_t status
);

  word_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign status.full     = (count == QCNT_W'(QDEPTH));
  assign status.nonempty = (count != '0);
  assign status.level    = count;
  assign do_push = push && !status.full;
  assign do_pop  = pop && status.nonempty;
  assign rd_word = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/ilp_mac.sv
// Shared multiply-add with range check: acc * base + digit against a limit.
// No dependencies.
module ilp_mac (
  input  logic [63:0] acc,
  input  logic [4:0]  digit,
  input  logic [4:0]  base,
  input  logic [63:0] lim,
  output logic [63:0] sum,
  output logic        bad
);

  logic [68:0] full;

  assign full = 69'(acc) * 69'(base) + 69'(digit);
  assign sum  = full[63:0];
  assign bad  = (digit >= base) || (full > {5'b0, lim});

endmodule

FILE: hw/rtl/ilp_back.sv
// Back end: runs the literal grammar, scales by the exponent, holds the result.
// Depends on ilp_pkg and ilp_mac.
module ilp_back import ilp_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  word_t                  q_word,
  output logic                   pop,
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic [VALUE_WIDTH-2:0] value,
  output logic                   valid_res
);

  localparam logic [63:0] MANT_LIM = 64'((65'd1 << VALUE_WIDTH) - 65'd1);

  bstate_t                  bstate, bstate_next;
  phase_t                   phase, phase_next;
  logic [VALUE_WIDTH-1:0]   mantissa, mantissa_next;
  logic [4:0]               radix, radix_next;
  logic [63:0]              power, power_next;
  logic                     failed, failed_next;
  logic                     digits_seen, digits_seen_next;
  logic                     exp_seen, exp_seen_next;
  logic [6:0]               count, count_next;
  logic                     res_valid_next;
  logic [VALUE_WIDTH-2:0]   value_next;
  logic                     valid_res_next;

  logic        use_power;
  logic [63:0] mac_acc;
  logic [4:0]  mac_digit;
  logic [4:0]  mac_base;
  logic [63:0] mac_lim;
  logic [63:0] mac_sum;
  logic        mac_bad;
  logic        phase_ok;
  logic        ok_now;
  logic [6:0]  count_lim;
  logic        fin;
  logic        finish;
  logic        res_ok;

  ilp_mac u_mac (
    .acc   (mac_acc),
    .digit (mac_digit),
    .base  (mac_base),
    .lim   (mac_lim),
    .sum   (mac_sum),
    .bad   (mac_bad)
  );

  always_comb begin
    case (phase)
      PH_HEAD:       phase_ok = digits_seen;
      PH_CLOSED:     phase_ok = 1'b1;
      PH_EXP_DIGITS: phase_ok = exp_seen;
      default:       phase_ok = 1'b0;
    endcase
  end

  assign ok_now    = !failed && phase_ok;
  assign count_lim = (|power[63:6]) ? SCALE_MAX : {1'b0, power[5:0]};
  assign fin       = !ok_now || (mantissa == '0) || (count == count_lim);
  assign res_ok    = ok_now && !mantissa[VALUE_WIDTH-1];

  always_comb begin
    bstate_next = bstate;
    case (bstate)
      BS_RUN:   if (q_valid && q_word.last) bstate_next = BS_SCALE;
      BS_SCALE: if (finish) bstate_next = BS_RUN;
      default:  bstate_next = BS_RUN;
    endcase
  end

  always_comb begin
    pop       = (bstate == BS_RUN) && q_valid;
    finish    = (bstate == BS_SCALE) && fin && (!res_valid || !res_stall);
    use_power = (bstate == BS_RUN) &&
                (((phase == PH_CLOSED) && (q_word.cls != CL_EXP)) ||
                 (phase == PH_EXP_START) || (phase == PH_EXP_DIGITS));
    mac_acc   = use_power ? power : 64'(mantissa);
    mac_lim   = use_power ? '1 : MANT_LIM;
    mac_digit = (bstate == BS_RUN) ? q_word.digit : 5'd0;
    mac_base  = (use_power || ((bstate == BS_RUN) && (phase == PH_HEAD))) ? RADIX_DEC
                                                                       : radix;
  end

  always_comb begin
    phase_next       = phase;
    mantissa_next    = mantissa;
    radix_next       = radix;
    power_next       = power;
    failed_next      = failed;
    digits_seen_next = digits_seen;
    exp_seen_next    = exp_seen;
    count_next       = count;
    res_valid_next   = res_valid && res_stall;
    value_next       = value;
    valid_res_next   = valid_res;

    if (pop && !failed && (q_word.cls != CL_UNDER)) begin
      case (phase)
        PH_HEAD: begin
          if (q_word.cls == CL_HASH) begin
            if (!digits_seen || (mantissa < VALUE_WIDTH'(RADIX_MIN)) ||
                (mantissa > VALUE_WIDTH'(RADIX_MAX))) begin
              failed_next = 1'b1;
            end else begin
              radix_next       = mantissa[4:0];
              mantissa_next    = '0;
              digits_seen_next = 1'b0;
              phase_next       = PH_BASED;
            end
          end else if (q_word.cls == CL_EXP) begin
            if (!digits_seen) failed_next = 1'b1;
            else phase_next = PH_EXP_START;
          end else if (mac_bad) begin
            failed_next = 1'b1;
          end else begin
            mantissa_next    = mac_sum[VALUE_WIDTH-1:0];
            digits_seen_next = 1'b1;
          end
        end
        PH_BASED: begin
          if (q_word.cls == CL_HASH) begin
            if (!digits_seen) failed_next = 1'b1;
            else phase_next = PH_CLOSED;
          end else if (mac_bad) begin
            failed_next = 1'b1;
          end else begin
            mantissa_next    = mac_sum[VALUE_WIDTH-1:0];
            digits_seen_next = 1'b1;
          end
        end
        PH_CLOSED, PH_EXP_START, PH_EXP_DIGITS: begin
          if ((phase == PH_CLOSED) && (q_word.cls == CL_EXP)) begin
            phase_next = PH_EXP_START;
          end else if ((phase != PH_EXP_DIGITS) && (q_word.cls == CL_PLUS)) begin
            phase_next = PH_EXP_DIGITS;
          end else begin
            phase_next = PH_EXP_DIGITS;
            if (mac_bad) begin
              failed_next = 1'b1;
            end else begin
              power_next    = mac_sum;
              exp_seen_next = 1'b1;
            end
          end
        end
        default: failed_next = 1'b1;
      endcase
    end

    if ((bstate == BS_SCALE) && !fin) begin
      if (mac_bad) begin
        failed_next = 1'b1;
      end else begin
        mantissa_next = mac_sum[VALUE_WIDTH-1:0];
        count_next    = count + 7'd1;
      end
    end

    if (finish) begin
      res_valid_next   = 1'b1;
      value_next       = res_ok ? mantissa[VALUE_WIDTH-2:0] : '0;
      valid_res_next   = res_ok;
      phase_next       = PH_HEAD;
      mantissa_next    = '0;
      radix_next       = RADIX_DEC;
      power_next       = '0;
      failed_next      = 1'b0;
      digits_seen_next = 1'b0;
      exp_seen_next    = 1'b0;
      count_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate      <= BS_RUN;
      phase       <= PH_HEAD;
      mantissa    <= '0;
      radix       <= RADIX_DEC;
      power       <= '0;
      failed      <= 1'b0;
      digits_seen <= 1'b0;
      exp_seen    <= 1'b0;
      count       <= '0;
      res_valid   <= 1'b0;
    end else begin
      bstate      <= bstate_next;
      phase       <= phase_next;
      mantissa    <= mantissa_next;
      radix       <= radix_next;
      power       <= power_next;
      failed      <= failed_next;
      digits_seen <= digits_seen_next;
      exp_seen    <= exp_seen_next;
      count       <= count_next;
      res_valid   <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value     <= value_next;
    valid_res <= valid_res_next;
  end

endmodule

FILE: hw/rtl/hdl_integer_literal_parser.sv
// Integer literal parser: characters in, one value word per literal out.
// After the last character is taken, the back end scales the mantissa by the exponent
// in the shared multiply-add unit, then registers the result. Throughput: one character
// per cycle while char_stall is low; the back end takes no characters while it scales.
// Reset (rst, synchronous): empties the queue, returns the parser to decimal start,
// drops any pending result.
`include "hdl_integer_literal_parser_macros.svh"

module hdl_integer_literal_parser import ilp_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   char_valid,
  output logic                   char_stall,
  input  logic [7:0]             character,
  input  logic                   last,
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic [VALUE_WIDTH-2:0] value,
  output logic                   valid_res
);

  word_t     f_word;
  word_t     q_word;
  q_status_t q_status;
  logic      pop;

  assign char_stall = q_status.full;

  ilp_front u_front (
    .character (character),
    .last      (last),
    .word      (f_word)
  );

  ilp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (char_valid),
    .wr_word (f_word),
    .pop     (pop),
    .rd_word (q_word),
    .status  (q_status)
  );

  ilp_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_status.nonempty),
    .q_word    (q_word),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .value     (value),
    .valid_res (valid_res)
  );

  `ILP_CHECK(a_pop_nonempty, clk, rst, pop, q_status.nonempty)
  `ILP_CHECK(a_level_bound, clk, rst, 1'b1, q_status.level <= QCNT_W'(QDEPTH))
  `ILP_CHECK(a_invalid_zero, clk, rst, res_valid && !valid_res, value == '0)
  `ILP_CHECK_NEXT(a_scale_after_last, clk, rst, pop && q_word.last, !pop)

endmodule
